@@ sv/json_string_utf8_to_utf16_core_macros.svh @@
// assertion macros shared by the json string decoder modules
// no dependencies; included by files that carry concurrent checks
`ifndef JSON_STRING_UTF8_TO_UTF16_CORE_MACROS_SVH
`define JSON_STRING_UTF8_TO_UTF16_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define JSU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define JSU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jsu_pkg.sv @@
// types, codes and helpers for the json string utf-8 to utf-16 decoder
// no dependencies; used by jsu_parser and json_string_utf8_to_utf16_core
package jsu_pkg;

    // one input beat
    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_of_string;
        logic       source_end;
    } jsu_in_t;

    // one result beat
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        string_done;
        logic [2:0]  error_code;
        logic        last_result;
    } jsu_out_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        jsu_out_t   first;
        jsu_out_t   second;
    } jsu_step_t;

    // parser modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_NORMAL = 3'd1;
    localparam logic [2:0] MODE_ESCAPE = 3'd2;
    localparam logic [2:0] MODE_HEX    = 3'd3;
    localparam logic [2:0] MODE_UTF8   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ERR_ESC_CUT   = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
    localparam logic [2:0] ERR_BAD_UTF8  = 3'd5;
    localparam logic [2:0] ERR_UNTERM    = 3'd6;

    // characters with a special meaning
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // surrogate bases
    localparam logic [15:0] SURR_HIGH = 16'hD800;
    localparam logic [15:0] SURR_LOW  = 16'hDC00;
    localparam logic [20:0] PLANE_ONE = 21'h10000;

    // result queue depth
    localparam int FIFO_DEPTH = 4;

    // hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ sv/jsu_parser.sv @@
// per-byte json string decoder: parse state, next-state and result logic
// depends on jsu_pkg and json_string_utf8_to_utf16_core_macros.svh
`include "json_string_utf8_to_utf16_core_macros.svh"

module jsu_parser
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  jsu_in_t   item,
    output jsu_step_t step
);

    logic [2:0]  mode_reg, mode_next;
    logic [20:0] acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;

    logic        emit;
    logic [20:0] emit_cp;
    logic        done;
    logic [2:0]  err;
    logic [4:0]  hex;
    logic [20:0] off;
    logic [7:0]  b;

    assign b   = item.byte_in;
    assign hex = hex_value(b);
    assign off = emit_cp - PLANE_ONE;

    // mode decode
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        emit      = 1'b0;
        emit_cp   = '0;
        done      = 1'b0;
        err       = ERR_NONE;
        if (item.start_of_string)
        begin
            acc_next  = '0;
            pend_next = '0;
            if (item.source_end || b != CH_QUOTE)
            begin
                err = ERR_NO_QUOTE;
            end
            else
            begin
                mode_next = MODE_NORMAL;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (item.source_end)
                    begin
                        err = ERR_UNTERM;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        mode_next = MODE_IDLE;
                        done      = 1'b1;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (!b[7])
                    begin
                        emit    = 1'b1;
                        emit_cp = {13'd0, b};
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        acc_next  = {16'd0, b[4:0]};
                        pend_next = 3'd1;
                        mode_next = MODE_UTF8;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        acc_next  = {17'd0, b[3:0]};
                        pend_next = 3'd2;
                        mode_next = MODE_UTF8;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        acc_next  = {18'd0, b[2:0]};
                        pend_next = 3'd3;
                        mode_next = MODE_UTF8;
                    end
                    else
                    begin
                        err = ERR_BAD_UTF8;
                    end
                end
                MODE_ESCAPE:
                begin
                    if (item.source_end)
                    begin
                        err = ERR_ESC_CUT;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        emit      = 1'b1;
                        case (b)
                            CH_QUOTE:  emit_cp = 21'h22;
                            CH_BSLASH: emit_cp = 21'h5C;
                            CH_SLASH:  emit_cp = 21'h2F;
                            CH_B:      emit_cp = 21'h08;
                            CH_F:      emit_cp = 21'h0C;
                            CH_N:      emit_cp = 21'h0A;
                            CH_R:      emit_cp = 21'h0D;
                            CH_T:      emit_cp = 21'h09;
                            CH_U:
                            begin
                                emit      = 1'b0;
                                mode_next = MODE_HEX;
                                acc_next  = '0;
                                pend_next = 3'd4;
                            end
                            default:
                            begin
                                emit = 1'b0;
                                err  = ERR_BAD_ESC;
                            end
                        endcase
                    end
                end
                MODE_HEX:
                begin
                    if (item.source_end || !hex[4])
                    begin
                        err = ERR_BAD_HEX;
                    end
                    else
                    begin
                        acc_next  = {5'd0, acc_reg[11:0], hex[3:0]};
                        pend_next = pend_reg - 3'd1;
                        if (pend_next == 3'd0)
                        begin
                            mode_next = MODE_NORMAL;
                            emit      = 1'b1;
                            emit_cp   = acc_next;
                        end
                    end
                end
                MODE_UTF8:
                begin
                    if (item.source_end || b[7:6] != 2'b10)
                    begin
                        err = ERR_BAD_UTF8;
                    end
                    else
                    begin
                        acc_next  = {acc_reg[14:0], b[5:0]};
                        pend_next = pend_reg - 3'd1;
                        if (pend_next == 3'd0)
                        begin
                            mode_next = MODE_NORMAL;
                            emit      = 1'b1;
                            emit_cp   = acc_next;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
        // any error drops back to idle
        if (err != ERR_NONE)
        begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            pend_next = '0;
        end
    end

    // result formation
    always_comb
    begin
        step        = '0;
        if (err != ERR_NONE)
        begin
            step.count             = 2'd1;
            step.first.error_code  = err;
            step.first.last_result = 1'b1;
        end
        else if (done)
        begin
            step.count             = 2'd1;
            step.first.string_done = 1'b1;
            step.first.last_result = 1'b1;
        end
        else if (emit)
        begin
            step.first.unit_valid = 1'b1;
            if (emit_cp[20:16] == 5'd0)
            begin
                step.count             = 2'd1;
                step.first.code_unit   = emit_cp[15:0];
                step.first.last_result = 1'b1;
            end
            else
            begin
                // surrogate pair
                step.count              = 2'd2;
                step.first.code_unit    = SURR_HIGH + {5'd0, off[20:10]};
                step.second.code_unit   = SURR_LOW + {6'd0, off[9:0]};
                step.second.unit_valid  = 1'b1;
                step.second.last_result = 1'b1;
            end
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            pend_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

    // checks
    `JSU_ASSERT_NOW(a_pair_last, clk, rst_n, take && step.count == 2'd2, !step.first.last_result && step.second.last_result && step.second.unit_valid, "surrogate pair marks wrong last beat")
    `JSU_ASSERT_NOW(a_single_last, clk, rst_n, take && step.count == 2'd1, step.first.last_result, "single result not marked last")
    `JSU_ASSERT_NEXT(a_err_idle, clk, rst_n, take && step.count != 2'd0 && step.first.error_code != ERR_NONE, mode_reg == MODE_IDLE && pend_reg == 3'd0, "parser not idle after error")
    `JSU_ASSERT_NEXT(a_open_quote, clk, rst_n, take && item.start_of_string && !item.source_end && item.byte_in == CH_QUOTE, mode_reg == MODE_NORMAL && step.count == 2'd0 || mode_reg == MODE_NORMAL, "opening quote did not enter string")

endmodule

@@ sv/json_string_utf8_to_utf16_core.sv @@
// Streaming decoder for one JSON string literal: takes one byte per cycle on
// the input channel and returns UTF-16 code units, a done beat for the closing
// quote, or a numbered error beat. Each accepted byte yields zero, one or two
// result beats (two for a code point above 0xFFFF); the final beat of a byte
// carries last_result. A byte's first result beat is visible in the cycle
// after accept if the queue was empty. Input is taken every cycle while the
// four-entry result queue has room for two beats, so the rate is one byte per
// cycle, bounded by out_ready stalls and, for pairs, one popped beat per cycle.
// depends on jsu_pkg, jsu_parser and json_string_utf8_to_utf16_core_macros.svh
`include "json_string_utf8_to_utf16_core_macros.svh"

module json_string_utf8_to_utf16_core
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  jsu_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output jsu_out_t out_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic             take;
    logic             pop;
    jsu_step_t        step;
    jsu_out_t         fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus;

    // handshakes: room for a surrogate pair is required to take a beat
    assign in_ready  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign take      = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = fifo_reg[rd_ptr_reg];

    jsu_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_data),
        .step  (step)
    );

    // queue pointers
    always_comb
    begin
        wr_ptr_plus = wr_ptr_reg + PTR_W'(1);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (take)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(step.count);
            count_next  = count_reg + CNT_W'(step.count);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (take && step.count != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= step.first;
        end
        if (take && step.count == 2'd2)
        begin
            fifo_reg[wr_ptr_plus] <= step.second;
        end
    end

    // checks
    `JSU_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `JSU_ASSERT_NEXT(a_hold_count, clk, rst_n, out_valid && !out_ready, count_reg >= $past(count_reg), "results lost while stalled")
    `JSU_ASSERT_NEXT(a_push_seen, clk, rst_n, take && step.count != 2'd0 && !pop, out_valid, "pushed result not visible")

endmodule

@@ test/json_string_utf8_to_utf16_core_test.sv @@
// testbench for json_string_utf8_to_utf16_core: feeds quoted strings byte by byte and
// checks every utf-16 / done / error beat against an in-bench decoder
// depends on jsu_pkg and json_string_utf8_to_utf16_core
module json_string_utf8_to_utf16_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import jsu_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_TAIL   = 20;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BURSTY} ready_pattern_e;

    typedef enum {
        FAULT_UNTERM, FAULT_ESC_CUT, FAULT_BAD_ESC, FAULT_BAD_HEX,
        FAULT_UTF8_CUT, FAULT_BAD_LEAD, FAULT_NO_QUOTE, FAULT_RESTART
    } fault_e;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    jsu_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    jsu_out_t out_data;

    // decoder state mirrored in the bench
    logic [2:0]  dec_mode = MODE_IDLE;
    logic [20:0] dec_acc  = '0;
    logic [2:0]  dec_left = '0;
    jsu_out_t    predicted_units[$];

    int live_bytes    = 0;
    int beats_checked = 0;
    int units_seen    = 0;
    int strings_done  = 0;
    int error_beats   = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;

    json_string_utf8_to_utf16_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic jsu_in_t make_in(input logic [7:0] b, input logic sof, input logic eos);
        jsu_in_t x;
        x.byte_in         = b;
        x.start_of_string = sof;
        x.source_end      = eos;
        return x;
    endfunction

    function automatic jsu_out_t make_beat(input logic [15:0] unit, input logic valid,
                                           input logic done, input logic [2:0] err);
        jsu_out_t r;
        r.code_unit   = unit;
        r.unit_valid  = valid;
        r.string_done = done;
        r.error_code  = err;
        r.last_result = 1'b0;
        return r;
    endfunction

    // one code point as one unit or a surrogate pair
    function automatic jsu_step_t point_units(input logic [20:0] cp);
        jsu_step_t s;
        logic [20:0] off;
        s = '0;
        if (cp <= 21'h00FFFF)
        begin
            s.count = 2'd1;
            s.first = make_beat(cp[15:0], 1'b1, 1'b0, ERR_NONE);
        end
        else
        begin
            off      = cp - PLANE_ONE;
            s.count  = 2'd2;
            s.first  = make_beat(SURR_HIGH + {5'd0, off[20:10]}, 1'b1, 1'b0, ERR_NONE);
            s.second = make_beat(SURR_LOW + {6'd0, off[9:0]}, 1'b1, 1'b0, ERR_NONE);
        end
        return s;
    endfunction

    // error beat; decoder drops back to idle
    function automatic jsu_step_t fault_beat(input logic [2:0] err);
        jsu_step_t s;
        dec_mode = MODE_IDLE;
        dec_acc  = '0;
        dec_left = '0;
        s        = '0;
        s.count  = 2'd1;
        s.first  = make_beat(16'h0000, 1'b0, 1'b0, err);
        return s;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] b, output logic ok);
        ok = 1'b1;
        if (b >= 8'h30 && b <= 8'h39)
            return 4'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66)
            return 4'(b - 8'h61 + 8'd10);
        if (b >= 8'h41 && b <= 8'h46)
            return 4'(b - 8'h41 + 8'd10);
        ok = 1'b0;
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    // advance the decoder by one accepted byte and return the beats it causes
    function automatic jsu_step_t decode_step(input jsu_in_t x);
        jsu_step_t  s;
        logic [3:0] digit;
        logic       ok;
        s = '0;
        if (x.start_of_string)
        begin
            dec_acc  = '0;
            dec_left = '0;
            if (x.source_end || x.byte_in != CH_QUOTE)
                s = fault_beat(ERR_NO_QUOTE);
            else
                dec_mode = MODE_NORMAL;
        end
        else
        begin
            case (dec_mode)
                MODE_NORMAL:
                begin
                    if (x.source_end)
                        s = fault_beat(ERR_UNTERM);
                    else if (x.byte_in == CH_QUOTE)
                    begin
                        dec_mode = MODE_IDLE;
                        s.count  = 2'd1;
                        s.first  = make_beat(16'h0000, 1'b0, 1'b1, ERR_NONE);
                    end
                    else if (x.byte_in == CH_BSLASH)
                        dec_mode = MODE_ESCAPE;
                    else if (!x.byte_in[7])
                        s = point_units({13'd0, x.byte_in});
                    else if (x.byte_in[7:5] == 3'b110)
                    begin
                        dec_acc  = {16'd0, x.byte_in[4:0]};
                        dec_left = 3'd1;
                        dec_mode = MODE_UTF8;
                    end
                    else if (x.byte_in[7:4] == 4'b1110)
                    begin
                        dec_acc  = {17'd0, x.byte_in[3:0]};
                        dec_left = 3'd2;
                        dec_mode = MODE_UTF8;
                    end
                    else if (x.byte_in[7:3] == 5'b11110)
                    begin
                        dec_acc  = {18'd0, x.byte_in[2:0]};
                        dec_left = 3'd3;
                        dec_mode = MODE_UTF8;
                    end
                    else
                        s = fault_beat(ERR_BAD_UTF8);
                end
                MODE_ESCAPE:
                begin
                    if (x.source_end)
                        s = fault_beat(ERR_ESC_CUT);
                    else
                    begin
                        dec_mode = MODE_NORMAL;
                        case (x.byte_in)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: s = point_units({13'd0, x.byte_in});
                            CH_B: s = point_units(21'h08);
                            CH_F: s = point_units(21'h0C);
                            CH_N: s = point_units(21'h0A);
                            CH_R: s = point_units(21'h0D);
                            CH_T: s = point_units(21'h09);
                            CH_U:
                            begin
                                dec_mode = MODE_HEX;
                                dec_acc  = '0;
                                dec_left = 3'd4;
                            end
                            default: s = fault_beat(ERR_BAD_ESC);
                        endcase
                    end
                end
                MODE_HEX:
                begin
                    digit = nibble_of(x.byte_in, ok);
                    if (x.source_end || !ok)
                        s = fault_beat(ERR_BAD_HEX);
                    else
                    begin
                        dec_acc  = {5'd0, dec_acc[11:0], digit};
                        dec_left = dec_left - 3'd1;
                        if (dec_left == 3'd0)
                        begin
                            dec_mode = MODE_NORMAL;
                            s = point_units(dec_acc);
                        end
                    end
                end
                MODE_UTF8:
                begin
                    if (x.source_end || x.byte_in[7:6] != 2'b10)
                        s = fault_beat(ERR_BAD_UTF8);
                    else
                    begin
                        dec_acc  = {dec_acc[14:0], x.byte_in[5:0]};
                        dec_left = dec_left - 3'd1;
                        if (dec_left == 3'd0)
                        begin
                            dec_mode = MODE_NORMAL;
                            s = point_units(dec_acc);
                        end
                    end
                end
                default:
                    dec_mode = MODE_IDLE;
            endcase
        end
        // flag the final beat of this byte
        if (s.count == 2'd1)
            s.first.last_result = 1'b1;
        else if (s.count == 2'd2)
            s.second.last_result = 1'b1;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input jsu_out_t got, input jsu_out_t want);
        mismatches++;
        $display("%0t mismatch: %s got unit=%h valid=%b done=%b err=%0d last=%b, want unit=%h valid=%b done=%b err=%0d last=%b",
                 $realtime, what, got.code_unit, got.unit_valid, got.string_done,
                 got.error_code, got.last_result, want.code_unit, want.unit_valid,
                 want.string_done, want.error_code, want.last_result);
    endtask

    // monitor: values are stable at the falling edge and move at the next rising edge
    always @(negedge clk)
    begin
        jsu_step_t caused;
        jsu_out_t  want;
        if (rst_n)
        begin
            // predict beats for an accepted byte
            if (in_valid && in_ready)
            begin
                if (in_data.start_of_string || dec_mode != MODE_IDLE)
                    live_bytes++;
                caused = decode_step(in_data);
                if (caused.count != 2'd0)
                    predicted_units = {predicted_units, caused.first};
                if (caused.count == 2'd2)
                    predicted_units = {predicted_units, caused.second};
            end
            // check an accepted result beat
            if (out_valid && out_ready)
            begin
                beats_checked++;
                if (out_data.unit_valid === 1'b1)
                    units_seen++;
                if (out_data.string_done === 1'b1)
                    strings_done++;
                if (out_data.error_code !== ERR_NONE)
                    error_beats++;
                if (predicted_units.size() == 0)
                    report_mismatch("result beat with nothing pending", out_data, '0);
                else
                begin
                    want = predicted_units.pop_front();
                    if (out_data.code_unit !== want.code_unit ||
                        out_data.unit_valid !== want.unit_valid ||
                        out_data.string_done !== want.string_done ||
                        out_data.error_code !== want.error_code ||
                        out_data.last_result !== want.last_result)
                        report_mismatch("result beat differs", out_data, want);
                end
            end
            // watchdog on cycles where no beat moves
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no beat moved for %0d cycles, %0d results outstanding",
                         idle_cycles, predicted_units.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: ready follows a pattern that changes every so often
    initial
    begin
        ready_pattern_e pattern;
        int             pattern_left;
        int             stall_left;
        pattern      = READY_ALWAYS;
        pattern_left = 0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (pattern_left == 0)
            begin
                pattern      = ready_pattern_e'($urandom_range(0, 3));
                pattern_left = $urandom_range(32, 200);
            end
            pattern_left--;
            case (pattern)
                READY_ALWAYS: out_ready <= 1'b1;
                READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        out_ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left = $urandom_range(1, 12);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    // send one beat in bursts with random gaps; returns at the edge that takes it
    task automatic send_beat(input jsu_in_t beat);
        int   gap;
        logic taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_data  <= beat;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(make_in(b, 1'b0, 1'b0));
    endtask

    task automatic send_open();
        send_beat(make_in(CH_QUOTE, 1'b1, 1'b0));
    endtask

    task automatic stop_sending();
        in_valid  <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_all_units();
        while (predicted_units.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_hex_escape(input logic [15:0] v);
        int k;
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (k = 3; k >= 0; k--)
            send_byte(hex_char(v[k * 4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic send_utf8(input logic [20:0] cp, input int nbytes);
        case (nbytes)
            2:
            begin
                send_byte({3'b110, cp[10:6]});
                send_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                send_byte({4'b1110, cp[15:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                send_byte({5'b11110, cp[20:18]});
                send_byte({2'b10, cp[17:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // one well-formed piece of string content
    task automatic send_element();
        int          pick;
        int          n;
        logic [7:0]  b;
        logic [15:0] v;
        logic [20:0] cp;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            do
                b = 8'($urandom_range(0, 127));
            while (b == CH_QUOTE || b == CH_BSLASH);
            send_byte(b);
        end
        else if (pick < 6)
        begin
            case ($urandom_range(0, 7))
                0: b = CH_QUOTE;
                1: b = CH_BSLASH;
                2: b = CH_SLASH;
                3: b = CH_B;
                4: b = CH_F;
                5: b = CH_N;
                6: b = CH_R;
                default: b = CH_T;
            endcase
            send_byte(CH_BSLASH);
            send_byte(b);
        end
        else if (pick < 8)
        begin
            // lone and paired surrogates pass through unchanged
            v = ($urandom_range(0, 3) == 0) ? 16'hD800 + 16'($urandom_range(0, 16'h07FF))
                                            : 16'($urandom_range(0, 16'hFFFF));
            send_hex_escape(v);
        end
        else
        begin
            // overlong forms included on purpose
            n = $urandom_range(2, 4);
            if (n == 2)
                cp = 21'($urandom_range(0, 11'h7FF));
            else if (n == 3)
                cp = 21'($urandom_range(0, 16'hFFFF));
            else if ($urandom_range(0, 3) == 0)
                cp = 21'($urandom_range(0, 21'h1FFFFF));
            else
                cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            send_utf8(cp, n);
        end
    endtask

    // break the current string in one of several ways
    task automatic send_fault(input fault_e kind);
        int         k;
        int         n;
        logic [7:0] b;
        logic       ok;
        case (kind)
            FAULT_UNTERM:
                send_beat(make_in(8'($urandom), 1'b0, 1'b1));
            FAULT_ESC_CUT:
            begin
                send_byte(CH_BSLASH);
                send_beat(make_in(8'($urandom), 1'b0, 1'b1));
            end
            FAULT_BAD_ESC:
            begin
                do
                    b = 8'($urandom);
                while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
                       b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
                send_byte(CH_BSLASH);
                send_byte(b);
            end
            FAULT_BAD_HEX:
            begin
                send_byte(CH_BSLASH);
                send_byte(CH_U);
                repeat ($urandom_range(0, 3))
                    send_byte(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
                if ($urandom_range(0, 1) == 0)
                    send_beat(make_in(8'($urandom), 1'b0, 1'b1));
                else
                begin
                    do
                    begin
                        b = 8'($urandom);
                        void'(nibble_of(b, ok));
                    end
                    while (ok);
                    send_byte(b);
                end
            end
            FAULT_UTF8_CUT:
            begin
                n = $urandom_range(2, 4);
                if (n == 2)
                    send_byte({3'b110, 5'($urandom)});
                else if (n == 3)
                    send_byte({4'b1110, 4'($urandom)});
                else
                    send_byte({5'b11110, 3'($urandom)});
                for (k = $urandom_range(0, n - 2); k > 0; k--)
                    send_byte({2'b10, 6'($urandom)});
                if ($urandom_range(0, 1) == 0)
                    send_beat(make_in(8'($urandom), 1'b0, 1'b1));
                else
                begin
                    do
                        b = 8'($urandom);
                    while (b[7:6] == 2'b10);
                    send_byte(b);
                end
            end
            FAULT_BAD_LEAD:
                send_byte(($urandom_range(0, 1) == 0) ? 8'h80 + 8'($urandom_range(0, 63))
                                                      : 8'hF8 + 8'($urandom_range(0, 7)));
            FAULT_NO_QUOTE:
            begin
                if ($urandom_range(0, 1) == 0)
                    send_beat(make_in(8'($urandom), 1'b1, 1'b1));
                else
                begin
                    do
                        b = 8'($urandom);
                    while (b == CH_QUOTE);
                    send_beat(make_in(b, 1'b1, 1'b0));
                end
            end
            default:
            begin
                // a new opening quote in the middle restarts parsing
                send_open();
                repeat ($urandom_range(0, 2))
                    send_element();
                send_byte(CH_QUOTE);
            end
        endcase
        // trailing bytes while idle are dropped by the block
        if (kind != FAULT_RESTART)
            repeat ($urandom_range(0, 2))
                send_beat(make_in(8'($urandom), 1'b0, 1'($urandom_range(0, 1))));
    endtask

    task automatic send_random_string(input bit broken);
        int n;
        int cut;
        int k;
        n   = $urandom_range(0, 10);
        cut = broken ? $urandom_range(0, n) : n;
        send_open();
        for (k = 0; k < cut; k++)
            send_element();
        if (broken)
            send_fault(fault_e'($urandom_range(0, 7)));
        else
            send_byte(CH_QUOTE);
    endtask

    // start byte rules and bytes sent while idle
    task automatic test_start_checks();
        send_beat(make_in(8'hFF, 1'b1, 1'b0));
        send_beat(make_in(CH_QUOTE, 1'b1, 1'b1));
        send_byte(CH_QUOTE);
        send_beat(make_in(8'h00, 1'b0, 1'b1));
    endtask

    // ascii extremes, largest four-byte form, hex escape, closing quote
    task automatic test_unit_decoding();
        send_open();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_utf8(21'h1FFFFF, 4);
        send_hex_escape(16'hFA09);
        send_byte(CH_QUOTE);
    endtask

    // one broken string each: bad utf-8 lead, cut escape, bad escape, unterminated, bad hex, cut utf-8
    task automatic test_error_codes();
        send_open();
        send_byte(8'h80);
        send_open();
        send_byte(CH_BSLASH);
        send_beat(make_in(8'h00, 1'b0, 1'b1));
        send_open();
        send_byte(CH_BSLASH);
        send_byte(8'h78);
        send_open();
        send_beat(make_in(8'h00, 1'b0, 1'b1));
        send_open();
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_byte(8'h47);
        send_open();
        send_byte(8'hE2);
        send_byte(8'h41);
    endtask

    // mostly well-formed strings, the rest broken
    task automatic test_random_strings(input int target);
        while (live_bytes < target)
            send_random_string($urandom_range(0, 4) == 0);
    endtask

    // sender holds off until every pending beat has come out
    task automatic test_drain_pause();
        send_random_string(1'b0);
        stop_sending();
        wait_all_units();
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_start_checks();
        test_unit_decoding();
        test_error_codes();
        test_random_strings(250);
        test_drain_pause();
        test_random_strings(550);
        stop_sending();
        wait_all_units();
        repeat (DRAIN_TAIL) @(posedge clk);
        $display("decoded %0d bytes into %0d result beats: %0d code units, %0d closed strings,",
                 live_bytes, beats_checked, units_seen, strings_done);
        $display("%0d error beats, %0d mismatches", error_beats, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
